FILE: hw/rtl/pbwt_pkg.sv
// pbwt_pkg: types and constants shared by the protobuf wire tokenizer
// item structs for the byte and record channels, parser phases, record codes
// no dependencies
package pbwt_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CFG_W      = 32;

  // configuration register indexes
  localparam logic CFG_PASS_PAYLOAD = 1'b0;
  localparam logic CFG_SELECT_FIELD = 1'b1;

  // wire types carried in the low bits of a key
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [63:0] FIXED64_BYTES = 64'd8;
  localparam logic [63:0] FIXED32_BYTES = 64'd4;

  // varint may use at most ten bytes: a continuation on the tenth is an error
  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

  typedef enum logic [2:0] {
    PH_KEY     = 3'd0,
    PH_VALUE   = 3'd1,
    PH_LEN     = 3'd2,
    PH_FIXED   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DRAIN   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    RK_VARINT  = 3'd0,
    RK_FIXED64 = 3'd1,
    RK_LENGTH  = 3'd2,
    RK_FIXED32 = 3'd3,
    RK_PAYLOAD = 3'd4,
    RK_END     = 3'd5
  } record_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERLONG  = 2'd1,
    ST_BAD_WTYPE = 2'd2,
    ST_TRUNCATED = 2'd3
  } parse_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    record_kind_t  record_kind;
    logic [31:0]   field_number;
    logic [63:0]   field_value;
    logic          payload_end;
    parse_status_t parse_status;
    logic          last_of_run;
  } record_t;

endpackage

FILE: hw/rtl/protobuf_wire_tokenizer_unit.sv
// protobuf_wire_tokenizer_unit: top level of the protobuf wire tokenizer
// one byte per item in, field, payload and end records out through a small queue
// depends on pbwt_pkg
//
// Takes one message byte per cycle while not stalled and emits zero, one or two
// records for it (a field record, and an end record on the byte flagged
// end_of_message). The parser updates in the cycle the byte is accepted; its
// records go into a four-entry record queue whose head drives the output. Byte
// input is stalled while fewer than two queue entries are free, so with the
// output draining a record per cycle a new byte is taken every cycle. Bytes that
// yield two records lower the sustained rate only when the consumer cannot keep
// up with two per byte. Configuration writes take effect at the next edge and
// are meant for idle time.
module protobuf_wire_tokenizer_unit
  import pbwt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  byte_item_t       byte_item,
  output logic             record_valid,
  input  logic             record_stall,
  output record_t          record_item
);

  // configuration
  logic        pass_payload;
  logic [31:0] select_field;

  // parser state
  phase_t      phase, phase_step, phase_next;
  logic [63:0] accumulator, accumulator_step, accumulator_next;
  logic [3:0]  varint_bytes_seen, varint_bytes_seen_step, varint_bytes_seen_next;
  logic [31:0] current_field, current_field_step, current_field_next;
  logic [2:0]  current_wire_type, current_wire_type_step, current_wire_type_next;
  logic [63:0] bytes_left, bytes_left_step, bytes_left_next;
  parse_status_t error_code, error_code_step, error_code_next;

  // record queue
  record_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     fifo_count, fifo_count_next;

  logic        byte_accept, record_accept;
  logic [7:0]  b;
  logic        eom;
  logic [5:0]  take_shift;
  logic [63:0] acc_take;
  logic        vi_done, vi_long;
  logic [63:0] bl_dec;
  logic        bl_zero;
  logic        selected;

  logic          fld_emit;
  record_kind_t  fld_kind;
  logic [63:0]   fld_value;
  logic          fld_pend;
  parse_status_t end_status;
  record_t       rec0, rec1;
  logic [1:0]    push_count;

  assign b   = byte_item.data_byte;
  assign eom = byte_item.end_of_message;

  assign byte_stall    = fifo_count > (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign byte_accept   = byte_valid && !byte_stall;
  assign record_valid  = fifo_count != '0;
  assign record_accept = record_valid && !record_stall;
  assign record_item   = fifo_mem[rd_ptr];

  // varint byte take: 7 payload bits land at 7 * bytes seen, bits past 63 drop
  assign take_shift = 6'({2'b00, varint_bytes_seen} * 6'd7);
  assign acc_take   = accumulator | (64'(b[6:0]) << take_shift);
  assign vi_done    = !b[7];
  assign vi_long    = b[7] && (varint_bytes_seen >= VARINT_LAST_IDX);

  assign bl_dec   = (bytes_left != '0) ? bytes_left - 64'd1 : bytes_left;
  assign bl_zero  = bl_dec == '0;
  assign selected = (select_field == '0) || (select_field == current_field);

  // next state
  always_comb begin
    phase_step             = phase;
    accumulator_step       = accumulator;
    varint_bytes_seen_step = varint_bytes_seen;
    current_field_step     = current_field;
    current_wire_type_step = current_wire_type;
    bytes_left_step        = bytes_left;
    error_code_step        = error_code;
    unique case (phase)
      PH_KEY: begin
        accumulator_step       = acc_take;
        varint_bytes_seen_step = varint_bytes_seen + 4'd1;
        if (vi_long) begin
          error_code_step = ST_OVERLONG;
          phase_step      = PH_DRAIN;
        end else if (vi_done) begin
          current_field_step     = acc_take[34:3];
          current_wire_type_step = acc_take[2:0];
          accumulator_step       = '0;
          varint_bytes_seen_step = '0;
          case (acc_take[2:0])
            WT_VARINT: phase_step = PH_VALUE;
            WT_FIXED64: begin
              bytes_left_step = FIXED64_BYTES;
              phase_step      = PH_FIXED;
            end
            WT_LENGTH: phase_step = PH_LEN;
            WT_FIXED32: begin
              bytes_left_step = FIXED32_BYTES;
              phase_step      = PH_FIXED;
            end
            default: begin
              error_code_step = ST_BAD_WTYPE;
              phase_step      = PH_DRAIN;
            end
          endcase
        end
      end
      PH_VALUE, PH_LEN: begin
        accumulator_step       = acc_take;
        varint_bytes_seen_step = varint_bytes_seen + 4'd1;
        if (vi_long) begin
          error_code_step = ST_OVERLONG;
          phase_step      = PH_DRAIN;
        end else if (vi_done) begin
          accumulator_step       = '0;
          varint_bytes_seen_step = '0;
          if (phase == PH_VALUE) begin
            phase_step = PH_KEY;
          end else begin
            bytes_left_step = acc_take;
            phase_step      = (acc_take == '0) ? PH_KEY : PH_PAYLOAD;
          end
        end
      end
      PH_FIXED, PH_PAYLOAD: begin
        bytes_left_step = bl_dec;
        if (bl_zero) begin
          phase_step = PH_KEY;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
        phase_step = PH_DRAIN;
      end
    endcase

    // end of message returns every parser register to its reset value
    if (eom) begin
      phase_next             = PH_KEY;
      accumulator_next       = '0;
      varint_bytes_seen_next = '0;
      current_field_next     = '0;
      current_wire_type_next = '0;
      bytes_left_next        = '0;
      error_code_next        = ST_OK;
    end else begin
      phase_next             = phase_step;
      accumulator_next       = accumulator_step;
      varint_bytes_seen_next = varint_bytes_seen_step;
      current_field_next     = current_field_step;
      current_wire_type_next = current_wire_type_step;
      bytes_left_next        = bytes_left_step;
      error_code_next        = error_code_step;
    end
  end

  // records for this byte
  always_comb begin
    fld_emit  = 1'b0;
    fld_kind  = RK_VARINT;
    fld_value = '0;
    fld_pend  = 1'b0;
    unique case (phase)
      PH_VALUE: begin
        fld_emit  = vi_done && selected;
        fld_kind  = RK_VARINT;
        fld_value = acc_take;
      end
      PH_LEN: begin
        fld_emit  = vi_done && selected;
        fld_kind  = RK_LENGTH;
        fld_value = acc_take;
      end
      PH_FIXED: begin
        fld_emit = bl_zero && selected;
        fld_kind = (current_wire_type == WT_FIXED64) ? RK_FIXED64 : RK_FIXED32;
      end
      PH_PAYLOAD: begin
        fld_emit  = pass_payload && selected;
        fld_kind  = RK_PAYLOAD;
        fld_value = 64'(b);
        fld_pend  = bl_zero;
      end
      default: begin
      end
    endcase

    if (phase_step == PH_DRAIN) begin
      end_status = error_code_step;
    end else if (phase_step == PH_KEY && varint_bytes_seen_step == '0) begin
      end_status = ST_OK;
    end else begin
      end_status = ST_TRUNCATED;
    end

    rec1.record_kind  = RK_END;
    rec1.field_number = '0;
    rec1.field_value  = '0;
    rec1.payload_end  = 1'b0;
    rec1.parse_status = end_status;
    rec1.last_of_run  = 1'b1;

    if (fld_emit) begin
      rec0.record_kind  = fld_kind;
      rec0.field_number = current_field;
      rec0.field_value  = fld_value;
      rec0.payload_end  = fld_pend;
      rec0.parse_status = ST_OK;
      rec0.last_of_run  = !eom;
    end else begin
      rec0 = rec1;
    end

    push_count = {1'b0, fld_emit} + {1'b0, eom};
  end

  always_comb begin
    fifo_count_next = fifo_count;
    if (byte_accept) begin
      fifo_count_next = fifo_count_next + (FIFO_AW+1)'(push_count);
    end
    if (record_accept) begin
      fifo_count_next = fifo_count_next - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_payload      <= 1'b1;
      select_field      <= '0;
      phase             <= PH_KEY;
      accumulator       <= '0;
      varint_bytes_seen <= '0;
      current_field     <= '0;
      current_wire_type <= '0;
      bytes_left        <= '0;
      error_code        <= ST_OK;
      wr_ptr            <= '0;
      rd_ptr            <= '0;
      fifo_count        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PASS_PAYLOAD: pass_payload <= cfg_data[0];
          CFG_SELECT_FIELD: select_field <= cfg_data[31:0];
          default: begin
          end
        endcase
      end
      if (byte_accept) begin
        phase             <= phase_next;
        accumulator       <= accumulator_next;
        varint_bytes_seen <= varint_bytes_seen_next;
        current_field     <= current_field_next;
        current_wire_type <= current_wire_type_next;
        bytes_left        <= bytes_left_next;
        error_code        <= error_code_next;
        wr_ptr            <= wr_ptr + FIFO_AW'(push_count);
      end
      if (record_accept) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count_next;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (byte_accept && push_count != 2'd0) begin
      fifo_mem[wr_ptr] <= rec0;
    end
    if (byte_accept && push_count == 2'd2) begin
      fifo_mem[wr_ptr + FIFO_AW'(1)] <= rec1;
    end
  end

endmodule

FILE: verif/protobuf_wire_tokenizer_unit_tb.sv
// protobuf_wire_tokenizer_unit_tb: self-checking bench for the protobuf wire tokenizer
// a directed byte table, then random messages under several register settings, checked
// by a cycle-free model of the tokenizer; depends on pbwt_pkg and protobuf_wire_tokenizer_unit
`timescale 1ns / 1ps

module protobuf_wire_tokenizer_unit_tb;
  import pbwt_pkg::*;

  localparam int DIRECTED_ROWS = 27;
  localparam int BYTES_PER_PHASE = 130;
  localparam int LONG_HOLD_CYCLES = 300;

  // wire types the tokenizer rejects
  localparam logic [2:0] WT_START_GROUP = 3'd3;
  localparam logic [2:0] WT_END_GROUP   = 3'd4;
  localparam logic [2:0] WT_RESERVED6   = 3'd6;
  localparam logic [2:0] WT_RESERVED7   = 3'd7;

  typedef enum logic [1:0] {VARINT_MORE, VARINT_DONE, VARINT_OVERLONG} varint_step_t;

  typedef struct packed {
    logic [7:0]    data_byte;
    logic          last;
    logic          check_end;
    parse_status_t end_status;
  } directed_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             byte_valid;
  logic             byte_stall;
  byte_item_t       byte_item;
  logic             record_valid;
  logic             record_stall;
  record_t          record_item;

  // tokenizer model state and register copies
  logic          pass_payload_q;
  logic [31:0]   select_field_q;
  phase_t        parse_phase;
  logic [63:0]   varint_acc;
  int            varint_len;
  logic [31:0]   key_field;
  logic [2:0]    key_wire_type;
  logic [63:0]   bytes_to_go;
  parse_status_t stream_error;

  record_t expected_records[$];
  logic [7:0] message_bytes[$];
  int mismatches = 0;
  int stream_bytes = 0;
  logic idling_enabled = 1'b1;
  logic long_hold_request = 1'b0;

  // rows with check_end set yield only an end record with the given status
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // varint field 1 = 150, first bytes after reset
    '{8'h08, 1'b0, 1'b0, ST_OK}, '{8'h96, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b0, 1'b0, ST_OK},
    // length-delimited field 2 carrying the byte extremes
    '{8'h12, 1'b0, 1'b0, ST_OK}, '{8'h02, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    // fixed32 field 1
    '{8'h0D, 1'b0, 1'b0, ST_OK}, '{8'hAA, 1'b0, 1'b0, ST_OK}, '{8'h55, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    // zero-length field 3 closing the message cleanly
    '{8'h1A, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b0, ST_OK},
    // start-group wire type in the first key
    '{8'h0B, 1'b1, 1'b1, ST_BAD_WTYPE},
    // message ends inside the key
    '{8'h80, 1'b1, 1'b1, ST_TRUNCATED},
    // ten continuation bytes in a key, then the drained end byte
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_OVERLONG}
  };

  protobuf_wire_tokenizer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record_item  (record_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #400_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- model

  task automatic clear_tokenizer_state();
    parse_phase   = PH_KEY;
    varint_acc    = '0;
    varint_len    = 0;
    key_field     = '0;
    key_wire_type = '0;
    bytes_to_go   = '0;
    stream_error  = ST_OK;
  endtask

  function automatic varint_step_t take_varint(input logic [7:0] b);
    logic [63:0] grp;
    grp = {57'd0, b[6:0]};
    varint_acc = varint_acc | (grp << (7 * (varint_len % 10)));
    varint_len++;
    if (!b[7]) return VARINT_DONE;
    if (varint_len >= 10) return VARINT_OVERLONG;
    return VARINT_MORE;
  endfunction

  task automatic enter_drain(input parse_status_t code);
    stream_error = code;
    parse_phase  = PH_DRAIN;
  endtask

  function automatic logic field_selected();
    return select_field_q == '0 || select_field_q == key_field;
  endfunction

  function automatic record_t make_record(input record_kind_t kind, input logic [31:0] fld,
                                          input logic [63:0] val, input logic pend,
                                          input parse_status_t st);
    record_t r;
    r.record_kind  = kind;
    r.field_number = fld;
    r.field_value  = val;
    r.payload_end  = pend;
    r.parse_status = st;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  task automatic tokenize_byte(input byte_item_t it);
    record_t       outs [2];
    int            n;
    varint_step_t  vr;
    logic [63:0]   val;
    logic          last;
    parse_status_t st;
    n = 0;
    case (parse_phase)
      PH_KEY: begin
        vr = take_varint(it.data_byte);
        if (vr == VARINT_OVERLONG) begin
          enter_drain(ST_OVERLONG);
        end else if (vr == VARINT_DONE) begin
          key_field     = varint_acc[34:3];
          key_wire_type = varint_acc[2:0];
          varint_acc    = '0;
          varint_len    = 0;
          case (key_wire_type)
            WT_VARINT:  parse_phase = PH_VALUE;
            WT_FIXED64: begin
              bytes_to_go = FIXED64_BYTES;
              parse_phase = PH_FIXED;
            end
            WT_LENGTH:  parse_phase = PH_LEN;
            WT_FIXED32: begin
              bytes_to_go = FIXED32_BYTES;
              parse_phase = PH_FIXED;
            end
            default:    enter_drain(ST_BAD_WTYPE);
          endcase
        end
      end
      PH_VALUE, PH_LEN: begin
        vr = take_varint(it.data_byte);
        if (vr == VARINT_OVERLONG) begin
          enter_drain(ST_OVERLONG);
        end else if (vr == VARINT_DONE) begin
          val        = varint_acc;
          varint_acc = '0;
          varint_len = 0;
          if (parse_phase == PH_VALUE) begin
            if (field_selected()) begin
              outs[n] = make_record(RK_VARINT, key_field, val, 1'b0, ST_OK);
              n++;
            end
            parse_phase = PH_KEY;
          end else begin
            if (field_selected()) begin
              outs[n] = make_record(RK_LENGTH, key_field, val, 1'b0, ST_OK);
              n++;
            end
            bytes_to_go = val;
            parse_phase = (val == '0) ? PH_KEY : PH_PAYLOAD;
          end
        end
      end
      PH_FIXED: begin
        if (bytes_to_go != '0) bytes_to_go--;
        if (bytes_to_go == '0) begin
          if (field_selected()) begin
            outs[n] = make_record(key_wire_type == WT_FIXED64 ? RK_FIXED64 : RK_FIXED32,
                                  key_field, '0, 1'b0, ST_OK);
            n++;
          end
          parse_phase = PH_KEY;
        end
      end
      PH_PAYLOAD: begin
        if (bytes_to_go != '0) bytes_to_go--;
        last = (bytes_to_go == '0);
        if (pass_payload_q && field_selected()) begin
          outs[n] = make_record(RK_PAYLOAD, key_field, {56'd0, it.data_byte}, last, ST_OK);
          n++;
        end
        if (last) parse_phase = PH_KEY;
      end
      default: ;
    endcase
    if (it.end_of_message) begin
      if (parse_phase == PH_DRAIN) st = stream_error;
      else if (parse_phase == PH_KEY && varint_len == 0) st = ST_OK;
      else st = ST_TRUNCATED;
      outs[n] = make_record(RK_END, '0, '0, 1'b0, st);
      n++;
      clear_tokenizer_state();
    end
    if (n > 0) outs[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) expected_records.push_back(outs[k]);
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input byte_item_t it, input logic check_end,
                           input parse_status_t end_status);
    int gap;
    int queued;
    record_t end_rec;
    @(negedge clk);
    if (idling_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    forever begin
      @(posedge clk);
      if (!byte_stall) break;
    end
    stream_bytes++;
    queued = expected_records.size();
    tokenize_byte(it);
    if (check_end) begin
      while (expected_records.size() > queued) void'(expected_records.pop_back());
      end_rec = make_record(RK_END, '0, '0, 1'b0, end_status);
      end_rec.last_of_run = 1'b1;
      expected_records.push_back(end_rec);
    end
  endtask

  task automatic wait_for_drain();
    int waited;
    waited = 0;
    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_records.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    // records pass through the record queue after their byte, so allow for its depth
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings(input logic pass, input logic [31:0] sel);
    wait_for_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PASS_PAYLOAD;
    cfg_data  <= {31'd0, pass};
    @(negedge clk);
    cfg_index <= CFG_SELECT_FIELD;
    cfg_data  <= sel;
    @(negedge clk);
    cfg_we <= 1'b0;
    pass_payload_q = pass;
    select_field_q = sel;
  endtask

  // ---------------------------------------------------------------- message builder

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 4))
      0, 1, 2: return $urandom_range(0, 5);
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64'($urandom_range(1, 127));
      2:       return 64'($urandom_range(128, 1 << 21));
      3:       return '1;
      4:       return {$urandom, $urandom};
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [2:0] pick_bad_wire_type();
    case ($urandom_range(0, 3))
      0:       return WT_START_GROUP;
      1:       return WT_END_GROUP;
      2:       return WT_RESERVED6;
      default: return WT_RESERVED7;
    endcase
  endfunction

  // pad > 0 adds bytes past the minimal encoding, up to a total of ten bytes
  task automatic put_varint(input logic [63:0] v, input int pad);
    logic [63:0] rest;
    logic [7:0]  b;
    int          len;
    int          total;
    rest = v >> 7;
    len  = 1;
    while (rest != '0) begin
      rest = rest >> 7;
      len++;
    end
    total = (len + pad > 10) ? 10 : len + pad;
    rest  = v;
    for (int i = 0; i < total; i++) begin
      b = {(i < total - 1), rest[6:0]};
      // upper bits of a tenth byte fall past bit 63
      if (i == 9 && $urandom_range(0, 1) == 1) b[6:1] = 6'($urandom);
      rest = rest >> 7;
      message_bytes.push_back(b);
    end
  endtask

  task automatic add_key(input logic [31:0] fld, input logic [2:0] wt);
    logic [63:0] key;
    key = {29'd0, fld, wt};
    if ($urandom_range(0, 15) == 0) key[63:35] = 29'({$urandom, $urandom});
    put_varint(key, pick_pad());
  endtask

  task automatic add_good_field(output logic open_ended);
    logic [31:0] fld;
    int          n;
    open_ended = 1'b0;
    fld = pick_field();
    case ($urandom_range(0, 5))
      0, 1: begin
        add_key(fld, WT_VARINT);
        put_varint(pick_value(), pick_pad());
      end
      2, 3: begin
        add_key(fld, WT_LENGTH);
        if ($urandom_range(0, 24) == 0) begin
          // huge length: the message can only end inside the payload
          put_varint({$urandom, $urandom} | 64'd64, 0);
          n = $urandom_range(1, 4);
          open_ended = 1'b1;
        end else begin
          n = $urandom_range(0, 6);
          put_varint(64'(n), pick_pad());
        end
        repeat (n) message_bytes.push_back(rand_byte());
      end
      4: begin
        add_key(fld, WT_FIXED64);
        repeat (8) message_bytes.push_back(rand_byte());
      end
      default: begin
        add_key(fld, WT_FIXED32);
        repeat (4) message_bytes.push_back(rand_byte());
      end
    endcase
  endtask

  task automatic send_message();
    logic       open_ended;
    int         kind;
    int         cut;
    byte_item_t it;
    message_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12)) message_bytes.push_back(rand_byte());
    end else begin
      open_ended = 1'b0;
      repeat ($urandom_range(kind == 8 ? 0 : 1, 4)) begin
        if (!open_ended) add_good_field(open_ended);
      end
      if (kind == 8) begin
        case ($urandom_range(0, 2))
          0: add_key(pick_field(), pick_bad_wire_type());
          1: repeat (10) message_bytes.push_back(rand_byte() | 8'h80);
          default: begin
            add_key(pick_field(), WT_VARINT);
            repeat (10) message_bytes.push_back(rand_byte() | 8'h80);
          end
        endcase
        repeat ($urandom_range(0, 3)) message_bytes.push_back(rand_byte());
      end
      if (kind == 7) begin
        cut = $urandom_range(1, message_bytes.size());
        while (message_bytes.size() > cut) void'(message_bytes.pop_back());
      end
    end
    for (int i = 0; i < message_bytes.size(); i++) begin
      it.data_byte      = message_bytes[i];
      it.end_of_message = (i == message_bytes.size() - 1);
      send_byte(it, 1'b0, ST_OK);
    end
  endtask

  // ---------------------------------------------------------------- record side

  initial begin : record_sink
    int hold_left;
    hold_left = 0;
    record_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end else if (hold_left == 0 && idling_enabled && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 15);
      end
      if (hold_left > 0) begin
        record_stall <= 1'b1;
        hold_left--;
      end else begin
        record_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : record_check
    record_t want;
    if (!rst && record_valid && !record_stall) begin
      if (expected_records.size() == 0) begin
        $error("record with none expected: kind %0d field %0h value %0h",
               record_item.record_kind, record_item.field_number, record_item.field_value);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        compare_field("record_kind", want.record_kind, record_item.record_kind);
        compare_field("field_number", want.field_number, record_item.field_number);
        compare_field("field_value", want.field_value, record_item.field_value);
        compare_field("payload_end", want.payload_end, record_item.payload_end);
        compare_field("parse_status", want.parse_status, record_item.parse_status);
        compare_field("last_of_run", want.last_of_run, record_item.last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    byte_item_t it;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_PASS_PAYLOAD;
    cfg_data   = '0;
    byte_valid = 1'b0;
    byte_item  = '0;
    pass_payload_q = 1'b1;
    select_field_q = '0;
    clear_tokenizer_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      it.data_byte      = directed_rows[i].data_byte;
      it.end_of_message = directed_rows[i].last;
      send_byte(it, directed_rows[i].check_end, directed_rows[i].end_status);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: ;
        1: apply_settings(1'b0, 32'd0);
        2: apply_settings(1'b1, 32'd1);
        3: apply_settings(1'b0, 32'hFFFF_FFFF);
        4: apply_settings(1'b1, $urandom_range(1, 5));
        default: apply_settings(1'b1, 32'd0);
      endcase
      // sink holds off while bytes keep coming, so the record queue backs up
      if (p == 2) long_hold_request = 1'b1;
      stream_bytes = 0;
      while (stream_bytes < BYTES_PER_PHASE) begin
        idling_enabled = (p != 5) && ($urandom_range(0, 4) != 0);
        send_message();
      end
    end

    wait_for_drain();
    if (expected_records.size() != 0) begin
      $error("%0d expected records never arrived", expected_records.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pbwt_pkg.sv
hw/rtl/protobuf_wire_tokenizer_unit.sv
verif/protobuf_wire_tokenizer_unit_tb.sv
